[hdl/twsb_pkg.sv]
// Shared constants, codes and types of the time window snapshot buffer.
package twsb_pkg;

    // Geometry and field widths
    localparam int DEPTH     = 64;
    localparam int TIME_W    = 63;
    localparam int BYTES_W   = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TOT_W     = BYTES_W + $clog2(DEPTH);
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_STORED   = 2'd0,
        STAT_BACKWARD = 2'd1,
        STAT_QUERY    = 2'd2,
        STAT_CLEARED  = 2'd3
    } stat_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGE_EN    = 1'b0,
        CFG_AGE_LIMIT = 1'b1
    } cfg_idx_t;

    // One stored entry as seen by the neighbors of a cell
    typedef struct packed {
        logic               valid;
        logic [TIME_W-1:0]  ts;
        logic [BYTES_W-1:0] nbytes;
    } entry_t;

    // Query token that walks the chain and collects window counts
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] below;
        logic [CNT_W-1:0] above;
    } token_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } cell_ctl_t;

endpackage

[hdl/twsb_cell.sv]
// One cell of the entry chain: holds one entry and one stage of the query token path.
module twsb_cell
    import twsb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctl_t          ctl,
    input  logic               left_valid,
    input  entry_t             right_q,
    input  logic [TIME_W-1:0]  new_time,
    input  logic [BYTES_W-1:0] new_bytes,
    input  logic [TIME_W-1:0]  win_start,
    input  logic [TIME_W-1:0]  win_stop,
    input  token_t             tok_in,
    output entry_t             cell_q,
    output token_t             tok_out
);

    logic               valid_reg, valid_next;
    logic [TIME_W-1:0]  ts_reg, ts_next;
    logic [BYTES_W-1:0] nbytes_reg, nbytes_next;
    logic               tok_v_reg, tok_v_next;
    logic [CNT_W-1:0]   below_reg, below_next;
    logic [CNT_W-1:0]   above_reg, above_next;
    logic               below_hit, above_hit;

    // Entry update: clear beats shift beats append; append lands in the first free cell
    always_comb begin
        valid_next  = valid_reg;
        ts_next     = ts_reg;
        nbytes_next = nbytes_reg;
        priority if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next  = right_q.valid;
            ts_next     = right_q.ts;
            nbytes_next = right_q.nbytes;
        end else if (ctl.load && !valid_reg && left_valid) begin
            valid_next  = 1'b1;
            ts_next     = new_time;
            nbytes_next = new_bytes;
        end
    end

    // Window tests of this cell; a zero bound is open
    assign below_hit = valid_reg && (win_start != '0) && (ts_reg < win_start);
    assign above_hit = valid_reg && (win_stop != '0) && (ts_reg > win_stop);

    // Token stage: pass on and add this cell's hits
    always_comb begin
        tok_v_next = tok_in.valid;
        below_next = tok_in.below + CNT_W'(below_hit);
        above_next = tok_in.above + CNT_W'(above_hit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_v_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            tok_v_reg <= tok_v_next;
        end
        ts_reg     <= ts_next;
        nbytes_reg <= nbytes_next;
        below_reg  <= below_next;
        above_reg  <= above_next;
    end

    assign cell_q.valid   = valid_reg;
    assign cell_q.ts      = ts_reg;
    assign cell_q.nbytes  = nbytes_reg;
    assign tok_out.valid  = tok_v_reg;
    assign tok_out.below  = below_reg;
    assign tok_out.above  = above_reg;

endmodule

[hdl/time_window_snapshot_buffer_top.sv]
// Time window snapshot buffer: a chain of entry cells, oldest in cell 0, run by a sequencer.
//
// Input channel (s_valid/s_ready) takes one request per transaction: push an entry,
// query a time window, or clear. Request code three is dropped without a result.
// Result channel (m_valid/m_ready) returns one transaction per request.
// Config channel (cfg_valid/cfg_ready, always ready) writes age_limit_enable (index 0)
// and age_limit_ns (index 1); write it only while the block is idle.
// Requests are handled one at a time; s_ready is high only when the sequencer is idle.
// Steps from acceptance to result valid:
//   clear or backwards push: the cells clear on acceptance, then ST_DONE hands over the result
//   push: ST_AGE when age limiting is on, then ST_OVF, ST_PUSH and ST_DONE
//   query: ST_QUERY waits for the token that walks all DEPTH cells, then ST_DONE
// Entries are kept sorted by time, so age eviction walks cell 0 one entry per cycle.
// A finished result sits in the output register; the next request is accepted while it
// waits, and a following result holds in the sequencer until the receiver takes it.
// Reset (aresetn low, synchronous) empties the buffer and zeroes both config registers.
module time_window_snapshot_buffer_top
    import twsb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata,
    // Request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [REQ_W-1:0]     s_req_type,
    input  logic [TIME_W-1:0]    s_entry_time,
    input  logic [BYTES_W-1:0]   s_entry_bytes,
    input  logic [TIME_W-1:0]    s_window_start,
    input  logic [TIME_W-1:0]    s_window_stop,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STAT_W-1:0]    m_status,
    output logic [CNT_W-1:0]     m_evicted_count,
    output logic                 m_overflow_drop,
    output logic [CNT_W-1:0]     m_range_offset,
    output logic [CNT_W-1:0]     m_range_count,
    output logic [CNT_W-1:0]     m_entry_count,
    output logic [TOT_W-1:0]     m_total_bytes
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_AGE   = 6'b000010,
        ST_OVF   = 6'b000100,
        ST_PUSH  = 6'b001000,
        ST_QUERY = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic               age_en_reg, age_en_next;
    logic [TIME_W-1:0]  age_lim_reg, age_lim_next;
    logic [TIME_W-1:0]  req_time_reg, req_time_next;
    logic [BYTES_W-1:0] req_bytes_reg, req_bytes_next;
    logic [TIME_W-1:0]  wstart_reg, wstart_next;
    logic [TIME_W-1:0]  wstop_reg, wstop_next;
    logic [TIME_W-1:0]  newest_reg, newest_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   evict_reg, evict_next;
    logic               ovf_reg, ovf_next;
    stat_t              status_reg, status_next;
    logic [CNT_W-1:0]   roff_reg, roff_next;
    logic [CNT_W-1:0]   rcnt_reg, rcnt_next;
    logic               inject_reg, inject_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [CNT_W-1:0]   m_evict_reg, m_evict_next;
    logic               m_ovf_reg, m_ovf_next;
    logic [CNT_W-1:0]   m_roff_reg, m_roff_next;
    logic [CNT_W-1:0]   m_rcnt_reg, m_rcnt_next;
    logic [CNT_W-1:0]   m_count_reg, m_count_next;
    logic [TOT_W-1:0]   m_total_reg, m_total_next;

    cell_ctl_t          ctl;
    entry_t             cells  [DEPTH];
    entry_t             right_e[DEPTH];
    logic               left_v [DEPTH];
    token_t             tok_in [DEPTH];
    token_t             tok_out[DEPTH];
    token_t             tail_tok;
    logic [TIME_W-1:0]  age_diff;
    logic               head_old;
    logic [CNT_W-1:0]   upper_end;

    // Chain of cells with neighbor wiring
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_v[i]       = 1'b1;
            assign tok_in[i].valid = inject_reg;
            assign tok_in[i].below = '0;
            assign tok_in[i].above = '0;
        end else begin : g_body
            assign left_v[i] = cells[i-1].valid;
            assign tok_in[i] = tok_out[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_e[i] = '0;
        end else begin : g_mid
            assign right_e[i] = cells[i+1];
        end
        twsb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .left_valid(left_v[i]),
            .right_q   (right_e[i]),
            .new_time  (req_time_reg),
            .new_bytes (req_bytes_reg),
            .win_start (wstart_reg),
            .win_stop  (wstop_reg),
            .tok_in    (tok_in[i]),
            .cell_q    (cells[i]),
            .tok_out   (tok_out[i])
        );
    end

    assign tail_tok = tok_out[DEPTH-1];

    // Age test on the oldest entry
    assign age_diff = req_time_reg - cells[0].ts;
    assign head_old = cells[0].valid && (req_time_reg > cells[0].ts)
                      && (age_diff > age_lim_reg);

    // End of the window from the top: entries above the stop bound are cut
    assign upper_end = held_reg - tail_tok.above;

    // Config writes
    assign cfg_ready = 1'b1;
    always_comb begin
        age_en_next  = age_en_reg;
        age_lim_next = age_lim_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AGE_EN:    age_en_next  = cfg_wdata[0];
                CFG_AGE_LIMIT: age_lim_next = cfg_wdata;
                default:       age_en_next  = age_en_reg;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        req_time_next  = req_time_reg;
        req_bytes_next = req_bytes_reg;
        wstart_next    = wstart_reg;
        wstop_next     = wstop_reg;
        newest_next    = newest_reg;
        held_next      = held_reg;
        total_next     = total_reg;
        evict_next     = evict_reg;
        ovf_next       = ovf_reg;
        status_next    = status_reg;
        roff_next      = roff_reg;
        rcnt_next      = rcnt_reg;
        inject_next    = 1'b0;
        ctl            = '0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_evict_next   = m_evict_reg;
        m_ovf_next     = m_ovf_reg;
        m_roff_next    = m_roff_reg;
        m_rcnt_next    = m_rcnt_reg;
        m_count_next   = m_count_reg;
        m_total_next   = m_total_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_time_next  = s_entry_time;
                    req_bytes_next = s_entry_bytes;
                    wstart_next    = s_window_start;
                    wstop_next     = s_window_stop;
                    evict_next     = '0;
                    ovf_next       = 1'b0;
                    roff_next      = '0;
                    rcnt_next      = '0;
                    unique case (req_t'(s_req_type))
                        REQ_PUSH: begin
                            if ((held_reg != '0) && (s_entry_time < newest_reg)) begin
                                ctl.clear   = 1'b1;
                                held_next   = '0;
                                total_next  = '0;
                                status_next = STAT_BACKWARD;
                                state_next  = ST_DONE;
                            end else begin
                                status_next = STAT_STORED;
                                state_next  = age_en_reg ? ST_AGE : ST_OVF;
                            end
                        end
                        REQ_QUERY: begin
                            inject_next = 1'b1;
                            status_next = STAT_QUERY;
                            state_next  = ST_QUERY;
                        end
                        REQ_CLEAR: begin
                            ctl.clear   = 1'b1;
                            held_next   = '0;
                            total_next  = '0;
                            status_next = STAT_CLEARED;
                            state_next  = ST_DONE;
                        end
                        REQ_NONE: begin
                            state_next = ST_IDLE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            // Drop aged entries from the head, one per cycle
            ST_AGE: begin
                if (head_old) begin
                    ctl.shift  = 1'b1;
                    held_next  = held_reg - CNT_W'(1);
                    total_next = total_reg - TOT_W'(cells[0].nbytes);
                    evict_next = evict_reg + CNT_W'(1);
                end else begin
                    state_next = ST_OVF;
                end
            end
            // Make room when still full
            ST_OVF: begin
                if (held_reg == CNT_W'(DEPTH)) begin
                    ctl.shift  = 1'b1;
                    held_next  = held_reg - CNT_W'(1);
                    total_next = total_reg - TOT_W'(cells[0].nbytes);
                    evict_next = evict_reg + CNT_W'(1);
                    ovf_next   = 1'b1;
                end
                state_next = ST_PUSH;
            end
            // Append at the first free cell
            ST_PUSH: begin
                ctl.load    = 1'b1;
                held_next   = held_reg + CNT_W'(1);
                total_next  = total_reg + TOT_W'(req_bytes_reg);
                newest_next = req_time_reg;
                state_next  = ST_DONE;
            end
            // Wait for the token to leave the last cell
            ST_QUERY: begin
                if (tail_tok.valid) begin
                    roff_next  = tail_tok.below;
                    rcnt_next  = (upper_end > tail_tok.below)
                                 ? (upper_end - tail_tok.below) : '0;
                    state_next = ST_DONE;
                end
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_evict_next  = evict_reg;
                    m_ovf_next    = ovf_reg;
                    m_roff_next   = roff_reg;
                    m_rcnt_next   = rcnt_reg;
                    m_count_next  = held_reg;
                    m_total_next  = total_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            age_en_reg  <= 1'b0;
            age_lim_reg <= '0;
            held_reg    <= '0;
            total_reg   <= '0;
            inject_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            age_en_reg  <= age_en_next;
            age_lim_reg <= age_lim_next;
            held_reg    <= held_next;
            total_reg   <= total_next;
            inject_reg  <= inject_next;
            m_valid_reg <= m_valid_next;
        end
        req_time_reg  <= req_time_next;
        req_bytes_reg <= req_bytes_next;
        wstart_reg    <= wstart_next;
        wstop_reg     <= wstop_next;
        newest_reg    <= newest_next;
        evict_reg     <= evict_next;
        ovf_reg       <= ovf_next;
        status_reg    <= status_next;
        roff_reg      <= roff_next;
        rcnt_reg      <= rcnt_next;
        m_status_reg  <= m_status_next;
        m_evict_reg   <= m_evict_next;
        m_ovf_reg     <= m_ovf_next;
        m_roff_reg    <= m_roff_next;
        m_rcnt_reg    <= m_rcnt_next;
        m_count_reg   <= m_count_next;
        m_total_reg   <= m_total_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_evicted_count = m_evict_reg;
    assign m_overflow_drop = m_ovf_reg;
    assign m_range_offset  = m_roff_reg;
    assign m_range_count   = m_rcnt_reg;
    assign m_entry_count   = m_count_reg;
    assign m_total_bytes   = m_total_reg;

endmodule

[verif/time_window_snapshot_buffer_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the time window snapshot buffer top level.
module time_window_snapshot_buffer_top_tb;
    import twsb_pkg::*;

    localparam int                 CLK_PERIOD    = 10;
    localparam logic [TIME_W-1:0]  T_MAX         = {TIME_W{1'b1}};
    localparam logic [BYTES_W-1:0] B_MAX         = {BYTES_W{1'b1}};
    localparam int                 DRAIN_CYCLES  = 2 * DEPTH;
    localparam int                 PHASE_ITEMS   = 75;
    localparam int                 RANDOM_PHASES = 8;
    localparam int                 PRESSURE_AT   = 150;
    localparam int                 PRESSURE_LEN  = 400;

    // One request transaction as offered on the input channel
    typedef struct packed {
        req_t               req;
        logic [TIME_W-1:0]  t;
        logic [BYTES_W-1:0] nbytes;
        logic [TIME_W-1:0]  ws;
        logic [TIME_W-1:0]  we;
    } snap_req_t;

    // One result transaction
    typedef struct packed {
        stat_t              status;
        logic [CNT_W-1:0]   evicted;
        logic               ovf;
        logic [CNT_W-1:0]   roff;
        logic [CNT_W-1:0]   rcnt;
        logic [CNT_W-1:0]   held;
        logic [TOT_W-1:0]   total;
    } snap_rsp_t;

    // Receiver stall patterns
    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PATTERN} rdy_mode_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [TIME_W-1:0]    cfg_wdata      = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type     = '0;
    logic [TIME_W-1:0]    s_entry_time   = '0;
    logic [BYTES_W-1:0]   s_entry_bytes  = '0;
    logic [TIME_W-1:0]    s_window_start = '0;
    logic [TIME_W-1:0]    s_window_stop  = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [STAT_W-1:0]    m_status;
    logic [CNT_W-1:0]     m_evicted_count;
    logic                 m_overflow_drop;
    logic [CNT_W-1:0]     m_range_offset;
    logic [CNT_W-1:0]     m_range_count;
    logic [CNT_W-1:0]     m_entry_count;
    logic [TOT_W-1:0]     m_total_bytes;

    // Shadow copy of the buffer and its registers
    logic [TIME_W-1:0]    shadow_ts     [DEPTH];
    logic [BYTES_W-1:0]   shadow_nbytes [DEPTH];
    int unsigned          shadow_head      = 0;
    int unsigned          shadow_held      = 0;
    logic [TOT_W:0]       shadow_total     = '0;
    logic                 shadow_age_en    = 1'b0;
    logic [TIME_W-1:0]    shadow_age_limit = '0;

    snap_req_t            pending_reqs [$];
    snap_rsp_t            expected_rsps [$];
    snap_req_t            cur_req;
    logic                 req_fire       = 1'b0;
    int                   queued_items   = 0;
    int                   accepted_items = 0;
    int                   mismatch_count = 0;
    int                   burst_left     = 0;
    int                   gap_left       = 0;
    int                   hold_left      = 0;
    bit                   pressure_done  = 1'b0;
    rdy_mode_t            ready_mode     = RDY_ALWAYS;
    int                   mode_left      = 0;
    int unsigned          cycle_count    = 0;
    logic [TIME_W-1:0]    time_cursor    = '0;

    time_window_snapshot_buffer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_entry_time    (s_entry_time),
        .s_entry_bytes   (s_entry_bytes),
        .s_window_start  (s_window_start),
        .s_window_stop   (s_window_stop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_evicted_count (m_evicted_count),
        .m_overflow_drop (m_overflow_drop),
        .m_range_offset  (m_range_offset),
        .m_range_count   (m_range_count),
        .m_entry_count   (m_entry_count),
        .m_total_bytes   (m_total_bytes)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Random helpers
    function automatic logic [TIME_W-1:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return B_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Query bound: open, far, or near the newest pushed time
    function automatic logic [TIME_W-1:0] window_bound();
        logic [TIME_W-1:0] spread;
        spread = TIME_W'($urandom_range(0, 20000));
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return rand63();
            3:       return T_MAX;
            4, 5:    return (time_cursor > spread) ? time_cursor - spread : TIME_W'(1);
            default: return (T_MAX - time_cursor > spread) ? time_cursor + spread : T_MAX;
        endcase
    endfunction

    // Shadow buffer primitives
    function automatic void shadow_empty();
        shadow_head  = 0;
        shadow_held  = 0;
        shadow_total = '0;
    endfunction

    function automatic void shadow_drop_oldest();
        shadow_total = shadow_total - shadow_nbytes[shadow_head];
        shadow_head  = (shadow_head + 1) % DEPTH;
        shadow_held  = shadow_held - 1;
    endfunction

    // Apply one request to the shadow buffer; returns 0 when no result follows
    function automatic bit predict_response(input snap_req_t rq, output snap_rsp_t rsp);
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       slot;
        int unsigned       evicted;
        logic [TIME_W-1:0] oldest_ts;
        bit                aging;
        rsp     = '0;
        evicted = 0;
        if (rq.req == REQ_NONE)
            return 1'b0;
        case (rq.req)
            REQ_PUSH: begin
                if (shadow_held > 0 &&
                    rq.t < shadow_ts[(shadow_head + shadow_held - 1) % DEPTH]) begin
                    shadow_empty();
                    rsp.status = STAT_BACKWARD;
                end else begin
                    // age eviction from the oldest end
                    aging = shadow_age_en;
                    while (aging && shadow_held > 0) begin
                        oldest_ts = shadow_ts[shadow_head];
                        if (rq.t > oldest_ts && (rq.t - oldest_ts) > shadow_age_limit) begin
                            shadow_drop_oldest();
                            evicted++;
                        end else begin
                            aging = 1'b0;
                        end
                    end
                    if (shadow_held >= DEPTH) begin
                        shadow_drop_oldest();
                        evicted++;
                        rsp.ovf = 1'b1;
                    end
                    slot                = (shadow_head + shadow_held) % DEPTH;
                    shadow_ts[slot]     = rq.t;
                    shadow_nbytes[slot] = rq.nbytes;
                    shadow_held         = shadow_held + 1;
                    shadow_total        = shadow_total + rq.nbytes;
                    rsp.status          = STAT_STORED;
                    rsp.evicted         = CNT_W'(evicted);
                end
            end
            REQ_QUERY: begin
                lo = 0;
                hi = shadow_held;
                if (rq.ws != '0) begin
                    while (lo != hi && shadow_ts[(shadow_head + lo) % DEPTH] < rq.ws)
                        lo++;
                end
                if (rq.we != '0) begin
                    while (hi != lo && shadow_ts[(shadow_head + hi - 1) % DEPTH] > rq.we)
                        hi--;
                end
                rsp.roff   = CNT_W'(lo);
                rsp.rcnt   = CNT_W'(hi - lo);
                rsp.status = STAT_QUERY;
            end
            default: begin
                shadow_empty();
                rsp.status = STAT_CLEARED;
            end
        endcase
        rsp.held  = CNT_W'(shadow_held);
        rsp.total = shadow_total[TOT_W-1:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_item(input req_t req, input logic [TIME_W-1:0] t,
                              input logic [BYTES_W-1:0] nb,
                              input logic [TIME_W-1:0] ws, input logic [TIME_W-1:0] we);
        snap_req_t rq;
        rq.req    = req;
        rq.t      = t;
        rq.nbytes = nb;
        rq.ws     = ws;
        rq.we     = we;
        pending_reqs.insert(pending_reqs.size(), rq);
        if (req != REQ_NONE)
            queued_items++;
    endtask

    // One random sequence: mostly ascending push runs and queries, some noise
    task automatic add_random_sequence();
        int unsigned       kind;
        int unsigned       len;
        int unsigned       scale;
        logic [TIME_W-1:0] delta;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH, DEPTH + 12)
                                              : $urandom_range(3, 30);
            case ($urandom_range(0, 4))
                0:       time_cursor = rand63();
                1:       time_cursor = T_MAX - TIME_W'($urandom_range(0, 100000));
                default: ;
            endcase
            scale = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
                case (scale)
                    0:       delta = TIME_W'($urandom_range(0, 2));
                    1:       delta = TIME_W'($urandom_range(0, 300));
                    2:       delta = TIME_W'($urandom_range(0, 200000));
                    default: delta = rand63() >> $urandom_range(8, 40);
                endcase
                if (delta > T_MAX - time_cursor)
                    time_cursor = TIME_W'($urandom_range(0, 1000));
                else
                    time_cursor = time_cursor + delta;
                queue_item(REQ_PUSH, time_cursor, rand_bytes(), rand63(), rand63());
            end
        end else if (kind < 70) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                queue_item(REQ_QUERY, rand63(), $urandom, window_bound(), window_bound());
        end else if (kind < 80) begin
            // push earlier than the newest entry
            queue_item(REQ_PUSH, time_cursor >> $urandom_range(1, 8), rand_bytes(),
                       rand63(), rand63());
        end else if (kind < 93) begin
            queue_item(req_t'($urandom_range(0, 3)), rand63(), $urandom, rand63(), rand63());
        end else begin
            queue_item(REQ_CLEAR, rand63(), $urandom, rand63(), rand63());
        end
    endtask

    // Wait for the block to drain completely
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [TIME_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        if (idx == CFG_AGE_EN)
            shadow_age_en = value[0];
        else
            shadow_age_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Enable word carries random upper bits; only bit 0 counts
    task automatic set_age_config(input bit en, input logic [TIME_W-1:0] limit);
        logic [TIME_W-1:0] en_word;
        en_word    = rand63();
        en_word[0] = en;
        write_reg(CFG_AGE_EN, en_word);
        write_reg(CFG_AGE_LIMIT, limit);
    endtask

    // Request channel: sample the transaction and predict its result
    always @(posedge aclk) begin : req_sample
        snap_rsp_t rsp;
        req_fire = aresetn && s_valid && s_ready;
        if (req_fire) begin
            if (predict_response(cur_req, rsp))
                expected_rsps.insert(expected_rsps.size(), rsp);
            if (cur_req.req != REQ_NONE)
                accepted_items++;
        end
    end

    // Request driver: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_fire) begin
            // hold the offered transaction
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs[0];
            pending_reqs.delete(0);
            s_valid        <= 1'b1;
            s_req_type     <= cur_req.req;
            s_entry_time   <= cur_req.t;
            s_entry_bytes  <= cur_req.nbytes;
            s_window_start <= cur_req.ws;
            s_window_stop  <= cur_req.we;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result receiver: changing stall patterns plus one long hold-off
    always @(negedge aclk) begin
        cycle_count++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!pressure_done && accepted_items >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_LEN - 1;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = rdy_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:    m_ready <= (cycle_count % 3 != 0);
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin : rsp_check
        snap_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: result with none expected, status %0d", $time, m_status);
                mismatch_count++;
            end else begin
                want = expected_rsps[0];
                expected_rsps.delete(0);
                check_field("status", want.status, m_status);
                check_field("evicted_count", want.evicted, m_evicted_count);
                check_field("overflow_drop", want.ovf, m_overflow_drop);
                check_field("range_offset", want.roff, m_range_offset);
                check_field("range_count", want.rcnt, m_range_count);
                check_field("entry_count", want.held, m_entry_count);
                check_field("total_bytes", want.total, m_total_bytes);
            end
        end
    end

    // Stimulus sequence
    initial begin
        int                target;
        logic [TIME_W-1:0] limit;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, age limiting off
        queue_item(REQ_PUSH, '0, '0, '0, '0);
        queue_item(REQ_PUSH, 63'd100, B_MAX, '0, '0);
        queue_item(REQ_PUSH, 63'd100, 32'd1, '0, '0);
        queue_item(REQ_QUERY, '0, '0, '0, '0);
        queue_item(REQ_QUERY, '0, '0, 63'd100, 63'd100);
        queue_item(REQ_QUERY, '0, '0, 63'd200, '0);
        queue_item(REQ_QUERY, '0, '0, '0, 63'd50);
        queue_item(REQ_QUERY, '0, '0, T_MAX, T_MAX);
        queue_item(REQ_NONE, rand63(), $urandom, rand63(), rand63());
        queue_item(REQ_PUSH, 63'd99, 32'd7, '0, '0);
        queue_item(REQ_PUSH, T_MAX, B_MAX, '0, '0);
        queue_item(REQ_QUERY, '0, '0, '0, T_MAX - 1);
        queue_item(REQ_PUSH, '0, 32'd3, '0, '0);
        queue_item(REQ_PUSH, 63'd5, 32'd9, '0, '0);
        queue_item(REQ_CLEAR, '0, '0, '0, '0);
        queue_item(REQ_QUERY, '0, '0, '0, '0);
        wait_idle();

        // Zero age limit: anything strictly older goes
        set_age_config(1'b1, '0);
        queue_item(REQ_PUSH, 63'd10, 32'd5, '0, '0);
        queue_item(REQ_PUSH, 63'd10, 32'd6, '0, '0);
        queue_item(REQ_PUSH, 63'd11, 32'd7, '0, '0);
        queue_item(REQ_QUERY, '0, '0, '0, '0);
        wait_idle();

        // Largest age limit: nothing ever ages out
        set_age_config(1'b1, T_MAX);
        queue_item(REQ_CLEAR, '0, '0, '0, '0);
        queue_item(REQ_PUSH, '0, B_MAX, '0, '0);
        queue_item(REQ_PUSH, T_MAX, B_MAX, '0, '0);
        queue_item(REQ_QUERY, '0, '0, 63'd1, '0);
        wait_idle();

        // Random phases under varying settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0:       set_age_config(1'b0, rand63());
                1:       set_age_config(1'b1, TIME_W'($urandom_range(0, 300)));
                2:       set_age_config(1'b1, TIME_W'($urandom_range(1000, 100000)));
                default: begin
                    limit = rand63() >> $urandom_range(0, 40);
                    set_age_config(1'b1, limit);
                end
            endcase
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
                add_random_sequence();
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("time_window_snapshot_buffer_top verification clean");
        end else begin
            $display("time_window_snapshot_buffer_top verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("time_window_snapshot_buffer_top verification failed");
        $finish;
    end

endmodule
